// ===== hw/rtl/pdic_pkg.sv =====
// Shared types and constants for the per-dimension index compression block.
// Holds operation and error codes, field widths and the controller/datapath
// command and status structs. No dependencies.
package pdic_pkg;

    localparam int DIMS_DEF    = 8;
    localparam int MAX_IDX_DEF = 1024;

    localparam int OP_W        = 3;
    localparam int DIM_FIELD_W = 3;
    localparam int INDEX_W     = 11;
    localparam int POS_W       = 10;
    localparam int VALUE_W     = 11;
    localparam int ERR_W       = 2;
    localparam int NUM_DIMS_W  = 4;
    localparam int LIMIT_W     = 11;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [NUM_DIMS_W-1:0] NUM_DIMS_RST    = 4'd1;
    localparam logic [LIMIT_W-1:0]    INDEX_LIMIT_RST = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 3'd0,
        OP_MARK       = 3'd1,
        OP_FINALIZE   = 3'd2,
        OP_READ_COUNT = 3'd3,
        OP_READ_FWD   = 3'd4,
        OP_READ_INV   = 3'd5
    } op_t;

    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_READY = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_DIM   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_DIMS    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_LIMIT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic lookup;
        logic clear_start;
        logic sweep;
        logic fin_start;
        logic dim_start;
        logic scan;
        logic dim_done;
        logic respond;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sweep_last;
        logic            need_scan;
        logic            scan_last;
        logic            dim_last;
        logic            out_free;
    } ctl_sts_t;

endpackage

// ===== hw/rtl/pdic_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the presence bitmap and both index maps.
module pdic_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pdic_ctrl.sv =====
// Controller state machine of the index compression block.
// Sequences decode, clearing sweeps, the finalize walk and the response.
// Depends on pdic_pkg.
module pdic_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output pdic_pkg::ctl_cmd_t  cmd,
    input  pdic_pkg::ctl_sts_t  sts
);
    import pdic_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_SWEEP,
        S_FIN_DIM,
        S_FIN_SCAN,
        S_FIN_DRAIN,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                // Clearing pass over the presence bitmap after reset.
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.op)
                    OP_CLEAR:
                    begin
                        cmd.clear_start = 1'b1;
                        state_next      = S_SWEEP;
                    end
                    OP_FINALIZE:
                    begin
                        cmd.fin_start = 1'b1;
                        state_next    = S_FIN_DIM;
                    end
                    default:
                    begin
                        cmd.lookup = 1'b1;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_FIN_DIM:
            begin
                cmd.dim_start = 1'b1;
                state_next    = sts.need_scan ? S_FIN_SCAN : S_FIN_DRAIN;
            end
            S_FIN_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_FIN_DRAIN;
                end
            end
            S_FIN_DRAIN:
            begin
                // The last bitmap read of the dimension lands here.
                cmd.dim_done = 1'b1;
                state_next   = sts.dim_last ? S_RESP : S_FIN_DIM;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ===== hw/rtl/pdic_datapath.sv =====
// Datapath of the index compression block: item and config registers,
// presence bitmap, forward and inverse maps, counters and output register.
// Depends on pdic_pkg and pdic_ram.
module pdic_datapath #(
    parameter int DIMS    = pdic_pkg::DIMS_DEF,
    parameter int MAX_IDX = pdic_pkg::MAX_IDX_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pdic_pkg::ctl_cmd_t                   cmd,
    output pdic_pkg::ctl_sts_t                   sts,
    input  logic [23:0]                          s_tdata,
    input  logic [3:0]                           s_tuser,
    input  logic                                 cfg_we,
    input  logic [pdic_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [pdic_pkg::LIMIT_W-1:0]         cfg_wdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [23:0]                          m_tdata,
    output logic [2:0]                           m_tuser
);
    import pdic_pkg::*;

    localparam int DIM_W  = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int IDX_W  = $clog2(MAX_IDX);
    localparam int ADDR_W = DIM_W + IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int LIM_W  = $clog2(MAX_IDX + 1);
    localparam int CMP_W  = (LIM_W > LIMIT_W) ? LIM_W : LIMIT_W;

    localparam logic [CMP_W-1:0] MAX_IDX_C  = CMP_W'(MAX_IDX);
    localparam logic [7:0]       DIMS_C     = 8'(DIMS);
    localparam logic [7:0]       DIM_LAST_C = 8'(DIMS - 1);

    // Item registers.
    logic [OP_W-1:0]        op_reg;
    logic [DIM_FIELD_W-1:0] dim_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic [POS_W-1:0]       pos_reg;
    logic                   in_use_reg;

    // Configuration and block state.
    logic [NUM_DIMS_W-1:0]  num_dims_reg;
    logic [LIMIT_W-1:0]     index_limit_reg;
    logic                   maps_ready_reg;
    logic [LIM_W-1:0]       dim_counts_reg [DIMS];
    logic [LIM_W-1:0]       largest_reg;

    // Sweep and finalize walk.
    logic [ADDR_W-1:0]      sweep_reg;
    logic [DIM_W-1:0]       fd_reg;
    logic [IDX_W-1:0]       k_reg;
    logic [IDX_W-1:0]       pk_reg;
    logic                   pv_reg;
    logic [LIM_W-1:0]       cnt_reg;
    logic [LIM_W-1:0]       cnt_next;

    logic                   m_tvalid_reg;
    logic [23:0]            m_tdata_reg;
    logic [2:0]             m_tuser_reg;

    logic [CMP_W-1:0]       eff_lim;
    logic [CMP_W-1:0]       raw_ext;
    logic [CMP_W-1:0]       pos_ext;
    logic                   negative;
    logic                   raw_ge_lim;
    logic                   dim_ok;
    logic [DIM_W-1:0]       dsel;
    logic [LIM_W-1:0]       cnt_sel;
    logic                   fwd_ok;
    logic                   mark_we;
    logic                   map_we;

    logic                   prs_we;
    logic [ADDR_W-1:0]      prs_waddr;
    logic                   prs_wdata;
    logic                   prs_re;
    logic [ADDR_W-1:0]      prs_raddr;
    logic                   prs_rdata;
    logic [IDX_W-1:0]       fwd_rdata;
    logic [IDX_W-1:0]       inv_rdata;

    logic [VALUE_W-1:0]     res_value;
    logic                   res_hit;
    logic [ERR_W-1:0]       res_err;

    assign negative   = index_reg[INDEX_W-1];
    assign raw_ext    = CMP_W'(index_reg);
    assign pos_ext    = CMP_W'(pos_reg);
    assign eff_lim    = (CMP_W'(index_limit_reg) < MAX_IDX_C) ? CMP_W'(index_limit_reg)
                                                               : MAX_IDX_C;
    assign raw_ge_lim = (raw_ext >= eff_lim);
    assign dim_ok     = (8'(dim_reg) < 8'(num_dims_reg)) && (8'(dim_reg) < DIMS_C);
    assign dsel       = DIM_W'(dim_reg);
    assign cnt_sel    = dim_counts_reg[dsel];
    assign fwd_ok     = (pos_ext < CMP_W'(cnt_sel)) && (pos_ext < MAX_IDX_C);

    assign mark_we = cmd.lookup && (op_reg == OP_MARK) && dim_ok && in_use_reg
                     && !negative && !raw_ge_lim;

    // A present bit read in the cycle before, during the walk, becomes a map entry.
    assign map_we   = pv_reg && prs_rdata;
    assign cnt_next = cnt_reg + LIM_W'(map_we);

    assign prs_we    = cmd.sweep || mark_we;
    assign prs_waddr = cmd.sweep ? sweep_reg : {dsel, raw_ext[IDX_W-1:0]};
    assign prs_wdata = !cmd.sweep;
    assign prs_re    = cmd.lookup || cmd.scan;
    assign prs_raddr = cmd.scan ? {fd_reg, k_reg} : {dsel, raw_ext[IDX_W-1:0]};

    pdic_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_present (
        .clk   (clk),
        .we    (prs_we),
        .waddr (prs_waddr),
        .wdata (prs_wdata),
        .re    (prs_re),
        .raddr (prs_raddr),
        .rdata (prs_rdata)
    );

    pdic_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_forward (
        .clk   (clk),
        .we    (map_we),
        .waddr ({fd_reg, cnt_reg[IDX_W-1:0]}),
        .wdata (pk_reg),
        .re    (cmd.lookup),
        .raddr ({dsel, pos_ext[IDX_W-1:0]}),
        .rdata (fwd_rdata)
    );

    pdic_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_inverse (
        .clk   (clk),
        .we    (map_we),
        .waddr ({fd_reg, pk_reg}),
        .wdata (cnt_reg[IDX_W-1:0]),
        .re    (cmd.lookup),
        .raddr ({dsel, raw_ext[IDX_W-1:0]}),
        .rdata (inv_rdata)
    );

    // Result of the current item; RAM read data is held from the lookup.
    always_comb
    begin
        res_value = '0;
        res_hit   = 1'b0;
        res_err   = ERR_OK;
        case (op_reg) inside
            OP_MARK:
            begin
                if (!dim_ok)
                begin
                    res_err = ERR_BAD_DIM;
                end
                else if (in_use_reg && !negative && raw_ge_lim)
                begin
                    res_err = ERR_RANGE;
                end
            end
            OP_READ_COUNT, OP_READ_FWD, OP_READ_INV:
            begin
                if (!dim_ok)
                begin
                    res_err = ERR_BAD_DIM;
                end
                else if (!maps_ready_reg)
                begin
                    res_err = ERR_NOT_READY;
                end
                else if (op_reg == OP_READ_COUNT)
                begin
                    res_value = VALUE_W'(cnt_sel);
                    res_hit   = 1'b1;
                end
                else if (op_reg == OP_READ_FWD)
                begin
                    if (fwd_ok)
                    begin
                        res_value = VALUE_W'(fwd_rdata);
                        res_hit   = 1'b1;
                    end
                end
                else if (!negative)
                begin
                    if (raw_ge_lim)
                    begin
                        res_err = ERR_RANGE;
                    end
                    else if (prs_rdata)
                    begin
                        res_value = VALUE_W'(inv_rdata);
                        res_hit   = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= s_tuser[2:0];
            in_use_reg <= s_tuser[3];
            dim_reg    <= s_tdata[2:0];
            index_reg  <= s_tdata[13:3];
            pos_reg    <= s_tdata[23:14];
        end
        if (cmd.scan)
        begin
            pk_reg <= k_reg;
        end
        if (cmd.respond)
        begin
            m_tdata_reg <= {2'b00, VALUE_W'(largest_reg), res_value};
            m_tuser_reg <= {res_err, res_hit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg    <= NUM_DIMS_RST;
            index_limit_reg <= INDEX_LIMIT_RST;
            maps_ready_reg  <= 1'b0;
            largest_reg     <= '0;
            for (int i = 0; i < DIMS; i++)
            begin
                dim_counts_reg[i] <= '0;
            end
            sweep_reg       <= '0;
            fd_reg          <= '0;
            k_reg           <= '0;
            cnt_reg         <= '0;
            pv_reg          <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.sweep)
            begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
            if (cmd.clear_start)
            begin
                for (int i = 0; i < DIMS; i++)
                begin
                    dim_counts_reg[i] <= '0;
                end
                largest_reg    <= '0;
                maps_ready_reg <= 1'b0;
            end
            if (mark_we)
            begin
                maps_ready_reg <= 1'b0;
            end
            if (cmd.fin_start)
            begin
                fd_reg         <= '0;
                largest_reg    <= '0;
                maps_ready_reg <= 1'b1;
            end
            if (cmd.dim_start)
            begin
                k_reg   <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                if (cmd.scan)
                begin
                    k_reg <= k_reg + IDX_W'(1);
                end
            end
            pv_reg <= cmd.scan;
            if (cmd.dim_done)
            begin
                dim_counts_reg[fd_reg] <= cnt_next;
                if (cnt_next > largest_reg)
                begin
                    largest_reg <= cnt_next;
                end
                fd_reg <= fd_reg + DIM_W'(1);
            end
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_NUM_DIMS:    num_dims_reg    <= cfg_wdata[NUM_DIMS_W-1:0];
                    CFG_INDEX_LIMIT: index_limit_reg <= cfg_wdata;
                    default:         num_dims_reg    <= num_dims_reg;
                endcase
                maps_ready_reg <= 1'b0;
            end
            if (cmd.respond)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.op         = op_reg;
    assign sts.sweep_last = &sweep_reg;
    assign sts.need_scan  = (8'(fd_reg) < 8'(num_dims_reg)) && (eff_lim != '0);
    assign sts.scan_last  = (CMP_W'(k_reg) == (eff_lim - CMP_W'(1)));
    assign sts.dim_last   = (8'(fd_reg) == DIM_LAST_C);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_resp_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken result");

    a_resp_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |=> m_tvalid_reg)
        else $error("loaded result not presented");

    a_map_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        map_we |-> $past(cmd.scan))
        else $error("map written outside the finalize walk");

    a_present_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sweep && mark_we))
        else $error("mark collides with bitmap sweep");

endmodule

// ===== hw/rtl/per_dimension_index_compression.sv =====
// Per-dimension index compression: mark present indices, rank them, read maps.
// Mark and read items are taken one at a time; each result is registered before it is presented.
// Clear sweeps all 2**(clog2(DIMS)+clog2(MAX_IDX)) presence bits, one bit a cycle.
// Finalize walks every dimension in turn, scanning the bitmap up to the limit in used ones.
// After reset a clearing pass over all presence bits runs before tready rises;
// configuration writes are taken during it. Top level; depends on pdic_pkg, pdic_ctrl, pdic_datapath.
module per_dimension_index_compression #(
    parameter int DIMS    = pdic_pkg::DIMS_DEF,
    parameter int MAX_IDX = pdic_pkg::MAX_IDX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // dim[2:0], index[13:3], position[23:14]
    input  logic [3:0]                      s_tuser,   // operation[2:0], in_use[3]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // value[10:0], max_count[21:11], zero
    output logic [2:0]                      m_tuser,   // hit[0], error[2:1]
    input  logic                            cfg_we,
    input  logic [pdic_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pdic_pkg::LIMIT_W-1:0]    cfg_wdata
);
    import pdic_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    pdic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    pdic_datapath #(
        .DIMS    (DIMS),
        .MAX_IDX (MAX_IDX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
